[rtl/ppp_pkg.sv]
// Shared types, constants and fixed-point helpers of the point projector.
package ppp_pkg;

  localparam int FRAC = 16;
  localparam int TABLE_WORDS = 14;
  localparam int IDX_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam int DIV_IN_W = 34;
  localparam int DIV_QB = 32;
  localparam int DIV_LAT = DIV_QB + 2;

  localparam int SAT_W = 72;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sd2147483648);
  localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC - 1);

  localparam logic [1:0] ST_PROJECTED   = 2'd0;
  localparam logic [1:0] ST_BAD_FRUSTUM = 2'd1;
  localparam logic [1:0] ST_ZERO_W      = 2'd2;
  localparam logic [1:0] ST_LOAD_ACK    = 2'd3;

  typedef struct packed {
    logic [30:0]        tan_half_fov;
    logic [30:0]        aspect_override;
    logic signed [31:0] near_plane;
    logic signed [31:0] far_plane;
    logic [16:0]        viewport_min_x;
    logic [16:0]        viewport_min_y;
    logic [16:0]        viewport_size_x;
    logic [16:0]        viewport_size_y;
  } cfg_t;

  typedef struct packed {
    logic               project;
    logic               write_en;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] value;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

[rtl/ppp_front.sv]
// Front end: accepts commands, classifies them and queues them for the back end.
module ppp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [3:0]           word_index,
  input  logic signed [31:0]   word_value,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic signed [31:0]   point_z,
  output logic                 item_valid,
  output ppp_pkg::item_t       item
);
  import ppp_pkg::*;

  item_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  item_t             incoming;

  assign busy = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push = start && !busy;
  // The back end never stalls, so the head leaves in every cycle it is present.
  assign pop = (count != '0);
  assign item_valid = pop;
  assign item = queue[rd_ptr];

  always_comb begin
    incoming.project  = func;
    incoming.write_en = !func && (word_index < IDX_W'(TABLE_WORDS));
    incoming.idx      = word_index;
    incoming.value    = word_value;
    incoming.px       = point_x;
    incoming.py       = point_y;
    incoming.pz       = point_z;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/ppp_div.sv]
// Pipelined restoring divider: saturated signed (a * 2^FRAC) / b, one quotient bit per stage.
module ppp_div (
  input  logic                          clk,
  input  logic signed [ppp_pkg::DIV_IN_W-1:0] a,
  input  logic signed [ppp_pkg::DIV_IN_W-1:0] b,
  output logic signed [31:0]            q
);
  import ppp_pkg::*;

  localparam int NW = DIV_IN_W + FRAC;

  logic [DIV_IN_W-1:0] amag;
  logic [DIV_IN_W-1:0] bmag;
  logic [NW-1:0]       num;

  logic [DIV_IN_W-1:0] st_r   [DIV_QB+1];
  logic [DIV_QB-1:0]   st_low [DIV_QB+1];
  logic [DIV_QB-1:0]   st_q   [DIV_QB+1];
  logic [DIV_IN_W-1:0] st_b   [DIV_QB+1];
  logic                st_neg [DIV_QB+1];
  logic                st_ovf [DIV_QB+1];

  always_comb begin
    amag = a[DIV_IN_W-1] ? DIV_IN_W'(-a) : DIV_IN_W'(a);
    bmag = b[DIV_IN_W-1] ? DIV_IN_W'(-b) : DIV_IN_W'(b);
    num  = {amag, FRAC'(0)};
  end

  always_ff @(posedge clk) begin
    st_r[0]   <= DIV_IN_W'(num[NW-1:DIV_QB]);
    st_low[0] <= num[DIV_QB-1:0];
    st_q[0]   <= '0;
    st_b[0]   <= bmag;
    st_neg[0] <= a[DIV_IN_W-1] ^ b[DIV_IN_W-1];
    // The quotient reaches 2^32 or more exactly when the upper dividend part reaches b.
    st_ovf[0] <= (DIV_IN_W'(num[NW-1:DIV_QB]) >= bmag);
  end

  for (genvar k = 0; k < DIV_QB; k++) begin : g_stage
    logic [DIV_IN_W:0] trial;
    logic [DIV_IN_W:0] diff;
    logic              fits;

    always_comb begin
      trial = {st_r[k], st_low[k][DIV_QB-1]};
      diff  = trial - {1'b0, st_b[k]};
      fits  = (trial >= {1'b0, st_b[k]});
    end

    always_ff @(posedge clk) begin
      st_r[k+1]   <= fits ? diff[DIV_IN_W-1:0] : trial[DIV_IN_W-1:0];
      st_low[k+1] <= {st_low[k][DIV_QB-2:0], 1'b0};
      st_q[k+1]   <= {st_q[k][DIV_QB-2:0], fits};
      st_b[k+1]   <= st_b[k];
      st_neg[k+1] <= st_neg[k];
      st_ovf[k+1] <= st_ovf[k];
    end
  end

  always_ff @(posedge clk) begin
    if (st_ovf[DIV_QB]) begin
      q <= st_neg[DIV_QB] ? 32'sh80000000 : 32'sh7fffffff;
    end else if (!st_neg[DIV_QB]) begin
      q <= st_q[DIV_QB][31] ? 32'sh7fffffff : $signed(st_q[DIV_QB]);
    end else if (st_q[DIV_QB] > 32'h80000000) begin
      q <= 32'sh80000000;
    end else begin
      q <= $signed(~st_q[DIV_QB] + 32'd1);
    end
  end

endmodule

[rtl/ppp_back.sv]
// Back end: table storage and the free-running projection pipeline.
module ppp_back (
  input  logic               clk,
  input  logic               rst,
  input  ppp_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  ppp_pkg::item_t     in_item,
  output logic               done,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               in_front,
  output logic [1:0]         status
);
  import ppp_pkg::*;

  typedef struct packed {
    logic               project;
    logic               den_zero;
    logic signed [31:0] l0;
    logic signed [31:0] l1;
    logic signed [31:0] l2;
    logic signed [31:0] wid;
    logic signed [31:0] hgt;
    logic signed [31:0] fh;
  } lvl1_t;

  typedef struct packed {
    logic               project;
    logic               invalid;
    logic signed [31:0] l0;
    logic signed [31:0] l1;
    logic signed [31:0] l2;
    logic signed [31:0] cb;
    logic signed [31:0] cc;
    logic signed [31:0] cd;
    logic signed [31:0] wid;
    logic signed [31:0] hgt;
  } lvl2_t;

  typedef struct packed {
    logic               project;
    logic               invalid;
    logic               zero_w;
    logic signed [31:0] wid;
    logic signed [31:0] hgt;
  } lvl3_t;

  logic signed [31:0] tbl [TABLE_WORDS];

  logic signed [63:0] n64, f64, vsx64, vsy64, vmx64, vmy64;
  logic signed [DIV_IN_W-1:0] n_d, f_d, dz_d;

  // Stage 1
  logic               v1, proj1;
  logic signed [63:0] mp1 [9];
  logic signed [31:0] m3_1 [3];
  logic signed [31:0] wid1, hgt1;
  logic signed [63:0] wprod1, hprod1, fhprod1, nfprod1;

  // Stage 2
  logic               v2, proj2;
  logic signed [31:0] l2r [3];
  logic signed [31:0] num2, den2, fh2, nf2, wid2, hgt2;

  logic signed [31:0] q_asp, q_b, q_c, q_d;
  lvl1_t              dl1 [DIV_LAT];
  logic [DIV_LAT-1:0] vl1;
  lvl1_t              in1;

  // Stages 3 and 4
  logic               v3, v4;
  lvl1_t              s3, s4;
  logic signed [31:0] cb3, cc3, cd3, cb4, cc4, cd4;
  logic signed [63:0] fwprod3;
  logic signed [31:0] fw4;
  logic signed [DIV_IN_W-1:0] dx4, dy4;
  logic               invalid4;

  logic signed [31:0] q_a;
  lvl2_t              dl2 [DIV_LAT];
  logic [DIV_LAT-1:0] vl2;
  lvl2_t              in2;

  // Stages 5 and 6
  logic               v5, v6;
  lvl2_t              s5;
  logic signed [63:0] cxp5, cyp5, czp5;
  logic signed [31:0] cx6, cy6, cz6;
  lvl3_t              s6;
  logic signed [DIV_IN_W-1:0] w6;

  logic signed [31:0] q_nx, q_ny, q_nz;
  lvl3_t              dl3 [DIV_LAT];
  logic [DIV_LAT-1:0] vl3;

  // Stages 7 to 11
  logic               v7, v8, v9, v10;
  logic [1:0]         st7, st8, st9, st10;
  logic               fr7, fr8, fr9, fr10;
  logic signed [31:0] wid7, hgt7, wid8, hgt8, wid9, hgt9;
  logic signed [63:0] tx7, ty7, xp8, yp8, sxp10, syp10;
  logic signed [31:0] ux9, uy9;

  always_comb begin
    n64   = 64'(cfg.near_plane);
    f64   = 64'(cfg.far_plane);
    vsx64 = 64'($signed({1'b0, cfg.viewport_size_x}));
    vsy64 = 64'($signed({1'b0, cfg.viewport_size_y}));
    vmx64 = 64'($signed({1'b0, cfg.viewport_min_x}));
    vmy64 = 64'($signed({1'b0, cfg.viewport_min_y}));
    n_d   = DIV_IN_W'(cfg.near_plane);
    f_d   = DIV_IN_W'(cfg.far_plane);
    dz_d  = f_d - n_d;
  end

  // Loads leave the queue in order, so a later projection sees every earlier write.
  always_ff @(posedge clk) begin
    if (in_valid && in_item.write_en) begin
      tbl[in_item.idx] <= in_item.value;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mp1[i*3+0] <= 64'(tbl[i*4+0]) * 64'(in_item.px);
      mp1[i*3+1] <= 64'(tbl[i*4+1]) * 64'(in_item.py);
      mp1[i*3+2] <= 64'(tbl[i*4+2]) * 64'(in_item.pz);
      m3_1[i]    <= tbl[i*4+3];
    end
    proj1   <= in_item.project;
    wid1    <= tbl[12];
    hgt1    <= tbl[13];
    wprod1  <= 64'(tbl[12]) * vsx64;
    hprod1  <= 64'(tbl[13]) * vsy64;
    fhprod1 <= 64'($signed({1'b0, cfg.tan_half_fov})) * n64;
    nfprod1 <= n64 * f64;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      l2r[i] <= sat32(SAT_W'(mp1[i*3+0] >>> FRAC) + SAT_W'(mp1[i*3+1] >>> FRAC)
                      + SAT_W'(mp1[i*3+2] >>> FRAC) + SAT_W'(m3_1[i]));
    end
    num2  <= sat32(SAT_W'(wprod1 >>> FRAC));
    den2  <= sat32(SAT_W'(hprod1 >>> FRAC));
    fh2   <= sat32(SAT_W'(fhprod1 >>> FRAC));
    nf2   <= sat32(SAT_W'(nfprod1 >>> FRAC));
    proj2 <= proj1;
    wid2  <= wid1;
    hgt2  <= hgt1;
  end

  ppp_div u_div_aspect (
    .clk (clk),
    .a   (DIV_IN_W'(num2)),
    .b   (DIV_IN_W'(den2)),
    .q   (q_asp)
  );

  ppp_div u_div_b (
    .clk (clk),
    .a   (n_d + n_d),
    .b   (DIV_IN_W'(fh2) + DIV_IN_W'(fh2)),
    .q   (q_b)
  );

  ppp_div u_div_c (
    .clk (clk),
    .a   (-(n_d + f_d)),
    .b   (dz_d),
    .q   (q_c)
  );

  ppp_div u_div_d (
    .clk (clk),
    .a   (-(DIV_IN_W'(nf2) + DIV_IN_W'(nf2))),
    .b   (dz_d),
    .q   (q_d)
  );

  always_comb begin
    in1.project  = proj2;
    in1.den_zero = (den2 == '0);
    in1.l0       = l2r[0];
    in1.l1       = l2r[1];
    in1.l2       = l2r[2];
    in1.wid      = wid2;
    in1.hgt      = hgt2;
    in1.fh       = fh2;
  end

  always_ff @(posedge clk) begin
    dl1[0] <= in1;
    for (int k = 1; k < DIV_LAT; k++) begin
      dl1[k] <= dl1[k-1];
    end
  end

  always_ff @(posedge clk) begin
    s3      <= dl1[DIV_LAT-1];
    cb3     <= q_b;
    cc3     <= q_c;
    cd3     <= q_d;
    fwprod3 <= 64'(dl1[DIV_LAT-1].fh) *
               ((cfg.aspect_override != '0) ? 64'($signed({1'b0, cfg.aspect_override}))
                                            : 64'(q_asp));
    s4      <= s3;
    cb4     <= cb3;
    cc4     <= cc3;
    cd4     <= cd3;
    fw4     <= sat32(SAT_W'(fwprod3 >>> FRAC));
  end

  always_comb begin
    dx4 = DIV_IN_W'(fw4) + DIV_IN_W'(fw4);
    dy4 = DIV_IN_W'(s4.fh) + DIV_IN_W'(s4.fh);
    invalid4 = (s4.den_zero && (cfg.aspect_override == '0)) ||
               (cfg.near_plane <= 0) || (cfg.far_plane <= 0) ||
               (dx4 <= 0) || (dy4 <= 0) || (dz_d <= 0);
  end

  ppp_div u_div_a (
    .clk (clk),
    .a   (n_d + n_d),
    .b   (dx4),
    .q   (q_a)
  );

  always_comb begin
    in2.project = s4.project;
    in2.invalid = invalid4;
    in2.l0      = s4.l0;
    in2.l1      = s4.l1;
    in2.l2      = s4.l2;
    in2.cb      = cb4;
    in2.cc      = cc4;
    in2.cd      = cd4;
    in2.wid     = s4.wid;
    in2.hgt     = s4.hgt;
  end

  always_ff @(posedge clk) begin
    dl2[0] <= in2;
    for (int k = 1; k < DIV_LAT; k++) begin
      dl2[k] <= dl2[k-1];
    end
  end

  always_ff @(posedge clk) begin
    s5   <= dl2[DIV_LAT-1];
    cxp5 <= 64'(q_a) * 64'(dl2[DIV_LAT-1].l1);
    cyp5 <= 64'(dl2[DIV_LAT-1].cb) * 64'(dl2[DIV_LAT-1].l2);
    czp5 <= 64'(dl2[DIV_LAT-1].cc) * 64'(dl2[DIV_LAT-1].l0);

    cx6        <= sat32(SAT_W'(cxp5 >>> FRAC));
    cy6        <= sat32(SAT_W'(cyp5 >>> FRAC));
    cz6        <= sat32(SAT_W'(czp5 >>> FRAC) + SAT_W'(s5.cd));
    w6         <= -DIV_IN_W'(s5.l0);
    s6.project <= s5.project;
    s6.invalid <= s5.invalid;
    s6.zero_w  <= (s5.l0 == '0);
    s6.wid     <= s5.wid;
    s6.hgt     <= s5.hgt;
  end

  ppp_div u_div_nx (
    .clk (clk),
    .a   (DIV_IN_W'(cx6)),
    .b   (w6),
    .q   (q_nx)
  );

  ppp_div u_div_ny (
    .clk (clk),
    .a   (DIV_IN_W'(cy6)),
    .b   (w6),
    .q   (q_ny)
  );

  ppp_div u_div_nz (
    .clk (clk),
    .a   (DIV_IN_W'(cz6)),
    .b   (w6),
    .q   (q_nz)
  );

  always_ff @(posedge clk) begin
    dl3[0] <= s6;
    for (int k = 1; k < DIV_LAT; k++) begin
      dl3[k] <= dl3[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!dl3[DIV_LAT-1].project) begin
      st7 <= ST_LOAD_ACK;
    end else if (dl3[DIV_LAT-1].invalid) begin
      st7 <= ST_BAD_FRUSTUM;
    end else if (dl3[DIV_LAT-1].zero_w) begin
      st7 <= ST_ZERO_W;
    end else begin
      st7 <= ST_PROJECTED;
    end
    fr7  <= (q_nz > 0);
    tx7  <= 64'(q_nx >>> 1) + HALF_Q;
    ty7  <= 64'(q_ny >>> 1) + HALF_Q;
    wid7 <= dl3[DIV_LAT-1].wid;
    hgt7 <= dl3[DIV_LAT-1].hgt;

    st8  <= st7;
    fr8  <= fr7;
    xp8  <= tx7 * vsx64;
    yp8  <= ty7 * vsy64;
    wid8 <= wid7;
    hgt8 <= hgt7;

    st9  <= st8;
    fr9  <= fr8;
    ux9  <= sat32(SAT_W'(xp8 >>> FRAC) + SAT_W'(vmx64));
    uy9  <= sat32(SAT_W'(yp8 >>> FRAC) + SAT_W'(vmy64));
    wid9 <= wid8;
    hgt9 <= hgt8;

    st10  <= st9;
    fr10  <= fr9;
    sxp10 <= 64'(ux9) * 64'(wid9);
    syp10 <= 64'(uy9) * 64'(hgt9);

    status <= st10;
    if (st10 == ST_PROJECTED) begin
      screen_x <= sat32(SAT_W'(sxp10 >>> FRAC));
      screen_y <= sat32(SAT_W'(syp10 >>> FRAC));
      in_front <= fr10;
    end else begin
      screen_x <= '0;
      screen_y <= '0;
      in_front <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      vl1  <= '0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      vl2  <= '0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      vl3  <= '0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      v9   <= 1'b0;
      v10  <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      vl1  <= {vl1[DIV_LAT-2:0], v2};
      v3   <= vl1[DIV_LAT-1];
      v4   <= v3;
      vl2  <= {vl2[DIV_LAT-2:0], v4};
      v5   <= vl2[DIV_LAT-1];
      v6   <= v5;
      vl3  <= {vl3[DIV_LAT-2:0], v6};
      v7   <= vl3[DIV_LAT-1];
      v8   <= v7;
      v9   <= v8;
      v10  <= v9;
      done <= v10;
    end
  end

endmodule

[rtl/perspective_point_projector_top.sv]
// Top level: configuration registers, command queue front end and projection back end.
// Every command gives one result, strobed on done after its transfer.
// Throughput is one command per cycle, since every stage and divider is fully pipelined;
// results pass through three chained dividers (aspect/frustum terms, then A,
// then the divide by w). Synchronous reset clears the queue, the pipeline valids and the
// registers; the transform table holds no reset value. The receiver cannot stall.
module perspective_point_projector_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [3:0]         word_index,
  input  logic signed [31:0] word_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               done,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               in_front,
  output logic [1:0]         status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ppp_pkg::*;

  localparam logic [2:0] REG_TAN      = 3'd0;
  localparam logic [2:0] REG_ASPECT   = 3'd1;
  localparam logic [2:0] REG_NEAR     = 3'd2;
  localparam logic [2:0] REG_FAR      = 3'd3;
  localparam logic [2:0] REG_VMIN_X   = 3'd4;
  localparam logic [2:0] REG_VMIN_Y   = 3'd5;
  localparam logic [2:0] REG_VSIZE_X  = 3'd6;
  localparam logic [2:0] REG_VSIZE_Y  = 3'd7;

  cfg_t       cfg;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       item_valid;
  item_t      item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_TAN:     prdata = {1'b0, cfg.tan_half_fov};
      REG_ASPECT:  prdata = {1'b0, cfg.aspect_override};
      REG_NEAR:    prdata = cfg.near_plane;
      REG_FAR:     prdata = cfg.far_plane;
      REG_VMIN_X:  prdata = {15'd0, cfg.viewport_min_x};
      REG_VMIN_Y:  prdata = {15'd0, cfg.viewport_min_y};
      REG_VSIZE_X: prdata = {15'd0, cfg.viewport_size_x};
      REG_VSIZE_Y: prdata = {15'd0, cfg.viewport_size_y};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tan_half_fov    <= 31'd65536;
      cfg.aspect_override <= 31'd0;
      cfg.near_plane      <= 32'sd65536;
      cfg.far_plane       <= 32'sd65536000;
      cfg.viewport_min_x  <= 17'd0;
      cfg.viewport_min_y  <= 17'd0;
      cfg.viewport_size_x <= 17'd65536;
      cfg.viewport_size_y <= 17'd65536;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TAN:     cfg.tan_half_fov    <= pwdata[30:0];
        REG_ASPECT:  cfg.aspect_override <= pwdata[30:0];
        REG_NEAR:    cfg.near_plane      <= pwdata;
        REG_FAR:     cfg.far_plane       <= pwdata;
        REG_VMIN_X:  cfg.viewport_min_x  <= pwdata[16:0];
        REG_VMIN_Y:  cfg.viewport_min_y  <= pwdata[16:0];
        REG_VSIZE_X: cfg.viewport_size_x <= pwdata[16:0];
        REG_VSIZE_Y: cfg.viewport_size_y <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  ppp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .word_index (word_index),
    .word_value (word_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .item_valid (item_valid),
    .item       (item)
  );

  ppp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (item_valid),
    .in_item  (item),
    .done     (done),
    .screen_x (screen_x),
    .screen_y (screen_y),
    .in_front (in_front),
    .status   (status)
  );

endmodule
